// ----- sv/vip_pkg.sv -----
// Shared types and codes for the vegetation index pixel pipeline.
package vip_pkg;

  typedef enum logic [2:0] {
    MODE_NDVI  = 3'd0,
    MODE_EVI   = 3'd1,
    MODE_GNDVI = 3'd2,
    MODE_NDRE  = 3'd3,
    MODE_RDVI  = 3'd4,
    MODE_OSAVI = 3'd5,
    MODE_MSR   = 3'd6,
    MODE_NONE  = 3'd7
  } mode_t;

  localparam logic CFG_INDEX_MODE = 1'b0;
  localparam logic CFG_BANDS      = 1'b1;

  // How the tail of the pipe forms the result.
  typedef enum logic [1:0] {
    KIND_FIXED,
    KIND_RATIO,
    KIND_RDVI,
    KIND_MSR
  } kind_t;

  typedef struct packed {
    logic  ok;
    kind_t kind;
    logic  one;
  } side_t;

endpackage

// ----- sv/vip_front.sv -----
// Band selection, operand forming and special-case detection (two stages).
module vip_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int DW          = 25
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [15:0]         band1_sample,
  input  logic [15:0]         band2_sample,
  input  logic [15:0]         band3_sample,
  input  logic [15:0]         band4_sample,
  input  logic [15:0]         band5_sample,
  input  logic [2:0]          mode,
  input  logic [4:0]          bands,
  output logic                out_vld,
  output logic [DW-1:0]       a_out,
  output logic [DW-1:0]       den_out,
  output vip_pkg::side_t      side_out
);

  localparam int S  = SAMPLE_BITS;
  localparam int SW = DW + 1;

  // stage A: band roles
  logic         vld_a;
  logic [S-1:0] n_a, r_a, g_a, b_a, e_a;
  logic [2:0]   mode_a;
  logic         ok_a;
  logic         hn, hr, hg, hb, he, ok_c;

  always_comb begin
    hn = bands[4] | bands[3];
    hr = bands[2] | bands[1];
    hg = bands[1] | bands[0];
    hb = bands[0];
    he = bands[3] | bands[2];
    case (vip_pkg::mode_t'(mode))
      vip_pkg::MODE_NDVI:  ok_c = hn & hr;
      vip_pkg::MODE_EVI:   ok_c = hn & hr & hb;
      vip_pkg::MODE_GNDVI: ok_c = hn & hg;
      vip_pkg::MODE_NDRE:  ok_c = hn & he;
      vip_pkg::MODE_RDVI:  ok_c = hn & hr;
      vip_pkg::MODE_OSAVI: ok_c = hn & hr;
      vip_pkg::MODE_MSR:   ok_c = hn & hr;
      default:             ok_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (adv) begin
      vld_a <= in_vld;
    end
    if (adv) begin
      n_a    <= bands[4] ? band5_sample[S-1:0] : band4_sample[S-1:0];
      r_a    <= bands[2] ? band3_sample[S-1:0] : band2_sample[S-1:0];
      g_a    <= bands[1] ? band2_sample[S-1:0] : band1_sample[S-1:0];
      b_a    <= band1_sample[S-1:0];
      e_a    <= bands[3] ? band4_sample[S-1:0] : band3_sample[S-1:0];
      mode_a <= mode;
      ok_a   <= ok_c;
    end
  end

  // stage B: numerator/denominator and special cases
  logic signed [SW-1:0] ns, rs, gs, bs, es, num, den, an_f, ad_f;
  logic [2*S-1:0]       dd;
  logic [S:0]           ssum;
  logic [S+1:0]         r4;
  logic [DW-1:0]        an, ad, a_c, den_c;
  vip_pkg::side_t       side_c;

  always_comb begin
    ns = $signed(SW'(n_a));
    rs = $signed(SW'(r_a));
    gs = $signed(SW'(g_a));
    bs = $signed(SW'(b_a));
    es = $signed(SW'(e_a));
    case (vip_pkg::mode_t'(mode_a))
      vip_pkg::MODE_EVI: begin
        num = (ns - rs) * $signed(SW'(5));
        den = ns * $signed(SW'(2)) + rs * $signed(SW'(12))
              - bs * $signed(SW'(15)) + $signed(SW'(2));
      end
      vip_pkg::MODE_GNDVI: begin
        num = ns - gs;
        den = ns + gs;
      end
      vip_pkg::MODE_NDRE: begin
        num = ns - es;
        den = ns + es;
      end
      vip_pkg::MODE_OSAVI: begin
        num = (ns - rs) * $signed(SW'(116));
        den = (ns + rs) * $signed(SW'(100)) + $signed(SW'(16));
      end
      default: begin
        num = ns - rs;
        den = ns + rs;
      end
    endcase
    an_f = num[SW-1] ? -num : num;
    ad_f = den[SW-1] ? -den : den;
    an   = an_f[DW-1:0];
    ad   = ad_f[DW-1:0];
    dd   = (2*S)'(n_a - r_a) * (2*S)'(n_a - r_a);
    ssum = (S+1)'(n_a) + (S+1)'(r_a);
    r4   = {r_a, 2'b00};

    side_c.ok   = ok_a;
    side_c.kind = vip_pkg::KIND_FIXED;
    side_c.one  = 1'b0;
    a_c         = an;
    den_c       = ad;
    case (vip_pkg::mode_t'(mode_a))
      vip_pkg::MODE_RDVI: begin
        a_c   = dd[DW-1:0];
        den_c = DW'(ssum);
        if (n_a <= r_a) begin
          side_c.one = 1'b0;
        end else if ((2*S+1)'(dd) >= (2*S+1)'(ssum)) begin
          side_c.one = 1'b1;
        end else begin
          side_c.kind = vip_pkg::KIND_RDVI;
        end
      end
      vip_pkg::MODE_MSR: begin
        a_c   = DW'(n_a);
        den_c = DW'(r_a);
        if (r_a == '0) begin
          side_c.one = (n_a != '0);
        end else if (n_a <= r_a) begin
          side_c.one = 1'b0;
        end else if ((S+2)'(n_a) >= r4) begin
          side_c.one = 1'b1;
        end else begin
          side_c.kind = vip_pkg::KIND_MSR;
        end
      end
      default: begin
        if (den == '0) begin
          side_c.one = (num > 0);
        end else if (num == '0 || (num[SW-1] != den[SW-1])) begin
          side_c.one = 1'b0;
        end else if (an >= ad) begin
          side_c.one = 1'b1;
        end else begin
          side_c.kind = vip_pkg::KIND_RATIO;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= vld_a;
    end
    if (adv) begin
      a_out    <= a_c;
      den_out  <= den_c;
      side_out <= side_c;
    end
  end

endmodule

// ----- sv/vip_div.sv -----
// Pipelined restoring divider, one quotient bit per stage: q = a * 2^(QW-2) / den.
module vip_div #(
  parameter int DW = 25,
  parameter int QW = 34
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  logic [DW-1:0]  a,
  input  logic [DW-1:0]  den,
  input  vip_pkg::side_t side_in,
  output logic           out_vld,
  output logic [QW-1:0]  q_out,
  output vip_pkg::side_t side_out
);

  localparam int RW = DW + 2;

  logic           vld  [QW+1];
  logic [RW-1:0]  rem  [QW+1];
  logic [DW-1:0]  dn   [QW+1];
  logic [QW-1:0]  q    [QW+1];
  vip_pkg::side_t side [QW+1];

  assign vld[0]  = in_vld;
  assign rem[0]  = {2'b00, a};
  assign dn[0]   = den;
  assign q[0]    = '0;
  assign side[0] = side_in;

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [RW-1:0] sh, thr, diff;
    logic          ge;
    // first two stages give the integer bits, the rest shift in fraction bits
    always_comb begin
      sh   = (i < 2) ? rem[i] : {rem[i][RW-2:0], 1'b0};
      thr  = (i == 0) ? {1'b0, dn[i], 1'b0} : {2'b00, dn[i]};
      ge   = (sh >= thr);
      diff = sh - thr;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
      if (adv) begin
        rem[i+1]  <= ge ? diff : sh;
        dn[i+1]   <= dn[i];
        q[i+1]    <= {q[i][QW-2:0], ge};
        side[i+1] <= side[i];
      end
    end
  end

  assign out_vld  = vld[QW];
  assign q_out    = q[QW];
  assign side_out = side[QW];

endmodule

// ----- sv/vip_sqrt.sv -----
// Pipelined integer square root, one root bit per stage; quotient carried alongside.
module vip_sqrt #(
  parameter int QW = 34,
  parameter int RW = 17
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  logic [QW-1:0]  v,
  input  vip_pkg::side_t side_in,
  output logic           out_vld,
  output logic [RW-1:0]  root_out,
  output logic [QW-1:0]  q_out,
  output vip_pkg::side_t side_out
);

  localparam int MW = RW + 3;

  logic           vld  [RW+1];
  logic [QW-1:0]  sv   [RW+1];
  logic [QW-1:0]  qk   [RW+1];
  logic [MW-1:0]  rem  [RW+1];
  logic [RW-1:0]  root [RW+1];
  vip_pkg::side_t side [RW+1];

  assign vld[0]  = in_vld;
  assign sv[0]   = v;
  assign qk[0]   = v;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = side_in;

  for (genvar j = 0; j < RW; j++) begin : g_step
    logic [MW-1:0] sh, trial, diff;
    logic          ge;
    always_comb begin
      sh    = {rem[j][MW-3:0], sv[j][QW-1:QW-2]};
      trial = {1'b0, root[j], 2'b01};
      ge    = (sh >= trial);
      diff  = sh - trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (adv) begin
        vld[j+1] <= vld[j];
      end
      if (adv) begin
        sv[j+1]   <= {sv[j][QW-3:0], 2'b00};
        qk[j+1]   <= qk[j];
        rem[j+1]  <= ge ? diff : sh;
        root[j+1] <= {root[j][RW-2:0], ge};
        side[j+1] <= side[j];
      end
    end
  end

  assign out_vld  = vld[RW];
  assign root_out = root[RW];
  assign q_out    = qk[RW];
  assign side_out = side[RW];

endmodule

// ----- sv/vegetation_index_pixel.sv -----
// Path: front stages, divider pipe, square root pipe, then the output register.
// Throughput: one pixel per cycle; set by the bit-per-stage divider and square root pipes.
// The whole pipe holds while a finished result waits and out_ready is low.
// Reset: synchronous, clears all stage valid bits, index_mode to NDVI and
// bands_present to all five bands.
module vegetation_index_pixel #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] band1_sample,
  input  logic [15:0] band2_sample,
  input  logic [15:0] band3_sample,
  input  logic [15:0] band4_sample,
  input  logic [15:0] band5_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] index_value,
  output logic        index_valid,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int DW = SAMPLE_BITS + 9;
  localparam int QW = 2 * FRAC_BITS + 2;
  localparam int RW = FRAC_BITS + 1;
  localparam int VW = FRAC_BITS + 1;

  logic [2:0] index_mode;
  logic [4:0] bands_present;
  logic       adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_mode    <= vip_pkg::MODE_NDVI;
      bands_present <= 5'b11111;
    end else if (cfg_we) begin
      if (cfg_index == vip_pkg::CFG_INDEX_MODE) begin
        index_mode <= cfg_data[2:0];
      end else begin
        bands_present <= cfg_data;
      end
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic           f_vld;
  logic [DW-1:0]  f_a, f_den;
  vip_pkg::side_t f_side;

  vip_front #(.SAMPLE_BITS(SAMPLE_BITS), .DW(DW)) u_front (
    .clk, .rst, .adv,
    .in_vld       (in_valid & in_ready),
    .band1_sample, .band2_sample, .band3_sample, .band4_sample, .band5_sample,
    .mode         (index_mode),
    .bands        (bands_present),
    .out_vld      (f_vld),
    .a_out        (f_a),
    .den_out      (f_den),
    .side_out     (f_side)
  );

  logic           d_vld;
  logic [QW-1:0]  d_q;
  vip_pkg::side_t d_side;

  vip_div #(.DW(DW), .QW(QW)) u_div (
    .clk, .rst, .adv,
    .in_vld   (f_vld),
    .a        (f_a),
    .den      (f_den),
    .side_in  (f_side),
    .out_vld  (d_vld),
    .q_out    (d_q),
    .side_out (d_side)
  );

  logic           s_vld;
  logic [RW-1:0]  s_root;
  logic [QW-1:0]  s_q;
  vip_pkg::side_t s_side;

  vip_sqrt #(.QW(QW), .RW(RW)) u_sqrt (
    .clk, .rst, .adv,
    .in_vld   (d_vld),
    .v        (d_q),
    .side_in  (d_side),
    .out_vld  (s_vld),
    .root_out (s_root),
    .q_out    (s_q),
    .side_out (s_side)
  );

  logic [VW-1:0]    one_q, val;
  logic [VW+16:0]   val_ext;

  always_comb begin
    one_q = {1'b1, {FRAC_BITS{1'b0}}};
    case (s_side.kind)
      vip_pkg::KIND_RATIO: val = {1'b0, s_q[2*FRAC_BITS-1:FRAC_BITS]};
      vip_pkg::KIND_RDVI:  val = s_root;
      vip_pkg::KIND_MSR:   val = s_root - one_q;
      default:             val = s_side.one ? one_q : '0;
    endcase
    if (!s_side.ok) begin
      val = '0;
    end
    val_ext = {17'd0, val};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s_vld;
    end
    if (adv) begin
      index_value <= val_ext[16:0];
      index_valid <= s_side.ok;
    end
  end

endmodule

// ----- test/tb.sv -----
// Testbench for vegetation_index_pixel: directed and random pixels checked against a predictor.
`timescale 1ns / 100ps

module tb;

  localparam int        DRAIN_CYCLES = 70;
  localparam int        WATCHDOG_MAX = 20000;
  localparam bit [16:0] ONE_Q        = 17'h10000;

  typedef struct {
    logic [16:0] value;
    logic        valid;
  } index_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] band1_sample;
  logic [15:0] band2_sample;
  logic [15:0] band3_sample;
  logic [15:0] band4_sample;
  logic [15:0] band5_sample;
  logic        out_valid;
  logic        out_ready;
  logic [16:0] index_value;
  logic        index_valid;
  logic        cfg_we;
  logic        cfg_index;
  logic [4:0]  cfg_data;

  vip_pkg::mode_t cur_mode;
  logic [4:0]     cur_bands;
  index_result_t  pending_indices[$];
  int             send_idle_pct;
  int             recv_stall_pct;
  int             errors;
  int             pixels_sent;
  int             results_seen;
  int             idle_count;
  bit             in_xfer;

  vegetation_index_pixel dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------- predictor ----------------
  // floor(num * 2^bits / den), one quotient bit per step
  function automatic longint unsigned scaled_div(longint unsigned num, longint unsigned den,
                                                 int bits);
    longint unsigned q;
    longint unsigned rem;
    q   = num / den;
    rem = num % den;
    for (int i = 0; i < bits; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned clamped_ratio(longint num, longint den);
    longint unsigned an;
    longint unsigned ad;
    if (den == 0) return (num > 0) ? ONE_Q : 0;
    if (num == 0 || ((num < 0) != (den < 0))) return 0;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    if (an >= ad) return ONE_Q;
    return scaled_div(an, ad, 16);
  endfunction

  function automatic index_result_t predict_index(logic [15:0] s1, logic [15:0] s2,
                                                   logic [15:0] s3, logic [15:0] s4,
                                                   logic [15:0] s5);
    index_result_t   res;
    bit              hn, hr, hg, hb, he, ok;
    longint          nir, red, grn, blu, edg;
    longint unsigned v;
    longint unsigned d;
    longint unsigned s;
    hn  = cur_bands[4] || cur_bands[3];
    nir = cur_bands[4] ? s5 : s4;
    hr  = cur_bands[2] || cur_bands[1];
    red = cur_bands[2] ? s3 : s2;
    hg  = cur_bands[1] || cur_bands[0];
    grn = cur_bands[1] ? s2 : s1;
    hb  = cur_bands[0];
    blu = s1;
    he  = cur_bands[3] || cur_bands[2];
    edg = cur_bands[3] ? s4 : s3;
    v   = 0;
    ok  = 1'b0;
    case (cur_mode)
      vip_pkg::MODE_NDVI: begin
        ok = hn && hr;
        v  = clamped_ratio(nir - red, nir + red);
      end
      vip_pkg::MODE_EVI: begin
        ok = hn && hr && hb;
        v  = clamped_ratio(5 * (nir - red), 2 * nir + 12 * red - 15 * blu + 2);
      end
      vip_pkg::MODE_GNDVI: begin
        ok = hn && hg;
        v  = clamped_ratio(nir - grn, nir + grn);
      end
      vip_pkg::MODE_NDRE: begin
        ok = hn && he;
        v  = clamped_ratio(nir - edg, nir + edg);
      end
      vip_pkg::MODE_RDVI: begin
        ok = hn && hr;
        if (nir > red) begin
          d = nir - red;
          s = nir + red;
          v = (d * d >= s) ? ONE_Q : int_sqrt(scaled_div(d * d, s, 32));
        end
      end
      vip_pkg::MODE_OSAVI: begin
        ok = hn && hr;
        v  = clamped_ratio(116 * (nir - red), 100 * (nir + red) + 16);
      end
      vip_pkg::MODE_MSR: begin
        ok = hn && hr;
        if (red == 0) v = (nir > 0) ? ONE_Q : 0;
        else if (nir <= red) v = 0;
        else if (nir >= 4 * red) v = ONE_Q;
        else v = int_sqrt(scaled_div(nir, red, 32)) - ONE_Q;
      end
      default: ok = 1'b0;
    endcase
    res.valid = ok;
    res.value = ok ? v[16:0] : 17'd0;
    return res;
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (recv_stall_pct == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // sample at the falling edge; the transfer lands on the next rising edge
  always @(negedge clk) begin
    index_result_t exp_r;
    in_xfer = !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_indices.size() == 0) begin
        $error("result with no pixel pending: index_value=%0d index_valid=%0b",
               index_value, index_valid);
        errors++;
      end else begin
        exp_r = pending_indices.pop_front();
        if (index_value !== exp_r.value) begin
          $error("index_value: expected %0d, got %0d", exp_r.value, index_value);
          errors++;
        end
        if (index_valid !== exp_r.valid) begin
          $error("index_valid: expected %0b, got %0b", exp_r.valid, index_valid);
          errors++;
        end
      end
    end
    if (!rst) begin
      if (in_xfer || (out_valid && out_ready)) idle_count = 0;
      else idle_count++;
      if (idle_count >= WATCHDOG_MAX) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_MAX);
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  // leaves the write enable high; the caller drops it after its last write
  task automatic write_reg(logic idx, logic [4:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == vip_pkg::CFG_INDEX_MODE) cur_mode = vip_pkg::mode_t'(data[2:0]);
    else cur_bands = data;
  endtask

  task automatic send_pixel(logic [15:0] s1, logic [15:0] s2, logic [15:0] s3,
                            logic [15:0] s4, logic [15:0] s5);
    bit acc;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid     <= 1'b1;
    band1_sample <= s1;
    band2_sample <= s2;
    band3_sample <= s3;
    band4_sample <= s4;
    band5_sample <= s5;
    do begin
      @(negedge clk);
      acc = in_valid && in_ready;
      @(posedge clk);
    end while (!acc);
    pending_indices.insert(pending_indices.size(), predict_index(s1, s2, s3, s4, s5));
    pixels_sent++;
  endtask

  // idle the input and let every pending result come out before a register write
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_indices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(vip_pkg::mode_t m, logic [4:0] bands);
    drain();
    write_reg(vip_pkg::CFG_INDEX_MODE, {2'b00, m});
    write_reg(vip_pkg::CFG_BANDS, bands);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample(int style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($urandom_range(15));
      default: return 16'($urandom_range(4095));
    endcase
  endfunction

  // pixels shaped so that most results land strictly inside (0,1)
  task automatic send_random_pixel();
    logic [15:0] r, n, b, s2, s4;
    int          style;
    style = $urandom_range(9);
    r  = rand_sample(style % 3);
    b  = rand_sample(style % 3);
    s2 = rand_sample(style % 3);
    s4 = rand_sample(style % 3);
    if (style < 6 && r != 0 && r < 16'd16000) begin
      // nir between red and four times red
      n = r + 16'($urandom_range(3 * r));
      if ($urandom_range(1)) b = 16'($urandom_range(r / 2));
    end else begin
      n = rand_sample(style % 3);
    end
    if ($urandom_range(3) == 0) s2 = n - 16'($urandom_range(n));
    if ($urandom_range(3) == 0) s4 = n - 16'($urandom_range(n));
    send_pixel(b, s2, r, s4, n);
  endtask

  // ---------------- tests ----------------
  task automatic test_reset_defaults();
    // reset state is NDVI with all bands
    send_pixel(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    send_pixel(16'd1, 16'd2, 16'd100, 16'd3, 16'd300);
  endtask

  task automatic test_each_mode();
    for (int m = int'(vip_pkg::MODE_EVI); m <= int'(vip_pkg::MODE_NONE); m++) begin
      configure(vip_pkg::mode_t'(m), 5'b11111);
      send_pixel(16'd10, 16'd200, 16'd300, 16'd500, 16'd900);
      send_pixel(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_pixel(16'd0, 16'd0, 16'd0, 16'd0, 16'd5000);
    end
    // EVI with a negative denominator from a large blue
    configure(vip_pkg::MODE_EVI, 5'b11111);
    send_pixel(16'hFFFF, 16'd0, 16'd10, 16'd0, 16'd20);
  endtask

  task automatic test_missing_bands();
    configure(vip_pkg::MODE_NDVI, 5'b00000);
    send_pixel(16'd1, 16'd2, 16'd3, 16'd4, 16'd9);
    configure(vip_pkg::MODE_GNDVI, 5'b01001);
    send_pixel(16'd100, 16'd2, 16'd3, 16'd400, 16'd9);
  endtask

  task automatic test_random();
    int idle_set[4][2] = '{'{0, 0}, '{69, 0}, '{0, 69}, '{7, 7}};
    for (int ph = 0; ph < 24; ph++) begin
      if (ph == 0) configure(vip_pkg::MODE_NDVI, 5'b11111);
      else if (ph % 8 == 7) configure(vip_pkg::MODE_NONE, 5'($urandom));
      else if (ph % 3 == 0) configure(vip_pkg::mode_t'(ph % 7), 5'($urandom));
      else configure(vip_pkg::mode_t'(ph % 7), 5'b11111);
      send_idle_pct  = idle_set[ph % 4][0];
      recv_stall_pct = idle_set[ph % 4][1];
      for (int i = 0; i < 21; i++) begin
        send_random_pixel();
        if (i == 10 && ph == 5) begin
          // hold the input until the pipe empties, then resume
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_indices.size() != 0) @(posedge clk);
        end
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    band1_sample   = '0;
    band2_sample   = '0;
    band3_sample   = '0;
    band4_sample   = '0;
    band5_sample   = '0;
    out_ready      = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = vip_pkg::CFG_INDEX_MODE;
    cfg_data       = '0;
    cur_mode       = vip_pkg::MODE_NDVI;
    cur_bands      = 5'b11111;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    errors         = 0;
    pixels_sent    = 0;
    results_seen   = 0;
    idle_count     = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_each_mode();
    test_missing_bands();
    test_random();
    drain();

    $display("covered %0d pixels over all index modes, band masks and idle patterns",
             pixels_sent);
    $display("checked %0d results, %0d mismatches", results_seen, errors);
    if (errors == 0 && pending_indices.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/vip_pkg.sv
sv/vip_front.sv
sv/vip_div.sv
sv/vip_sqrt.sv
sv/vegetation_index_pixel.sv
test/tb.sv
